@@ rtl/core/agc_gain_smoother_macros.svh @@
// assertion macros shared by the agc checker
`ifndef AGC_GAIN_SMOOTHER_MACROS_SVH
`define AGC_GAIN_SMOOTHER_MACROS_SVH

// same-cycle implication, checked outside reset
`define AGC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("agc port check failed");

// next-cycle implication, checked outside reset
`define AGC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("agc port check failed");

`endif

@@ rtl/core/agc_pkg.sv @@
// shared types and constants of the agc gain smoother
`timescale 1ns / 1ps
`default_nettype none

package agc_pkg;

  localparam int GAIN_W     = 16;
  localparam int GAIN_FRAC  = 8;
  localparam int COEF_W     = 17;
  localparam int COEF_FRAC  = 16;
  localparam int NUM_W      = GAIN_W + GAIN_FRAC;  // target_level << 8
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;
  localparam int M_TDATA_W  = 2 * GAIN_W;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_LEVEL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_GAIN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_GAIN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK_COEF  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_COEF = 3'd4;

  // reset values
  localparam logic [GAIN_W-1:0] TARGET_LEVEL_RST = 16'd16384;
  localparam logic [GAIN_W-1:0] MIN_GAIN_RST     = 16'd64;
  localparam logic [GAIN_W-1:0] MAX_GAIN_RST     = 16'd8192;
  localparam logic [COEF_W-1:0] ATTACK_COEF_RST  = 17'd6554;
  localparam logic [COEF_W-1:0] RELEASE_COEF_RST = 17'd655;
  localparam logic [GAIN_W-1:0] GAIN_ONE         = 16'd256;

  typedef struct packed {
    logic load;
    logic div_step;
    logic clamp;
    logic mul;
    logic commit;
  } agc_cmd_t;

  typedef struct packed {
    logic div_last;
  } agc_sts_t;

endpackage

`default_nettype wire

@@ rtl/core/agc_ctrl.sv @@
// sequencing state machine of the agc gain smoother
`timescale 1ns / 1ps
`default_nettype none

module agc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output agc_pkg::agc_cmd_t      cmd,
  input  wire agc_pkg::agc_sts_t sts
);
  import agc_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIV   = 3'd1;
  localparam logic [2:0] ST_CLAMP = 3'd2;
  localparam logic [2:0] ST_MUL   = 3'd3;
  localparam logic [2:0] ST_UPD   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       m_tvalid_next;

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = ST_CLAMP;
        end
      end
      ST_CLAMP: begin
        cmd.clamp  = 1'b1;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_UPD;
      end
      ST_UPD: begin
        // hold until the output register is free or being drained
        if (!m_tvalid || m_tready) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign m_tvalid_next = cmd.commit | (m_tvalid & ~m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      m_tvalid <= m_tvalid_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/agc_dp.sv @@
// datapath of the agc gain smoother: config, divider, clamp, multiply, update
`timescale 1ns / 1ps
`default_nettype none

module agc_dp #(
  parameter int LEVEL_BITS = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire agc_pkg::agc_cmd_t              cmd,
  output agc_pkg::agc_sts_t                   sts,
  input  wire logic [LEVEL_BITS-1:0]          level,
  input  wire logic                           cfg_we,
  input  wire logic [agc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [agc_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic [agc_pkg::GAIN_W-1:0]          gain,
  output logic [agc_pkg::GAIN_W-1:0]          goal_gain
);
  import agc_pkg::*;

  localparam int                 CNT_W    = $clog2(NUM_W);
  localparam logic [CNT_W-1:0]   DIV_LAST = CNT_W'(NUM_W - 1);

  // configuration registers
  logic [GAIN_W-1:0] target_level;
  logic [GAIN_W-1:0] min_gain;
  logic [GAIN_W-1:0] max_gain;
  logic [COEF_W-1:0] attack_coef;
  logic [COEF_W-1:0] release_coef;

  // state
  logic [GAIN_W-1:0] cur_gain;

  // divider
  logic [LEVEL_BITS-1:0] divisor;
  logic [LEVEL_BITS-1:0] rem;
  logic [NUM_W-1:0]      num;
  logic [CNT_W-1:0]      cnt;
  logic [LEVEL_BITS:0]   trial;
  logic [LEVEL_BITS:0]   diff;
  logic                  ge;

  // clamp / multiply / update
  logic [GAIN_W-1:0]          goal;
  logic [GAIN_W-1:0]          q_hi_clamp;
  logic [GAIN_W-1:0]          goal_next;
  logic                       rising;
  logic                       falling;
  logic [GAIN_W-1:0]          gap_comb;
  logic [COEF_W-1:0]          coef_sel;
  logic [GAIN_W+COEF_W-1:0]   prod;
  logic [GAIN_W-1:0]          gap;
  logic [COEF_W-1:0]          delta;
  logic                       up;
  logic                       down;
  logic [GAIN_W+1:0]          sum;
  logic [GAIN_W-1:0]          cur_gain_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_level <= TARGET_LEVEL_RST;
      min_gain     <= MIN_GAIN_RST;
      max_gain     <= MAX_GAIN_RST;
      attack_coef  <= ATTACK_COEF_RST;
      release_coef <= RELEASE_COEF_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TARGET_LEVEL: target_level <= cfg_data[GAIN_W-1:0];
        REG_MIN_GAIN:     min_gain     <= cfg_data[GAIN_W-1:0];
        REG_MAX_GAIN:     max_gain     <= cfg_data[GAIN_W-1:0];
        REG_ATTACK_COEF:  attack_coef  <= cfg_data;
        REG_RELEASE_COEF: release_coef <= cfg_data;
        default: ;
      endcase
    end
  end

  // restoring divider, one quotient bit per step, quotient shifts into num
  assign trial = {rem, num[NUM_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign ge    = (trial >= {1'b0, divisor});
  assign sts.div_last = (cnt == DIV_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.load) begin
      cnt <= '0;
    end else if (cmd.div_step) begin
      cnt <= cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      divisor <= (level == '0) ? LEVEL_BITS'(1) : level;
      rem     <= '0;
      num     <= {target_level, {GAIN_FRAC{1'b0}}};
    end else if (cmd.div_step) begin
      rem <= ge ? diff[LEVEL_BITS-1:0] : trial[LEVEL_BITS-1:0];
      num <= {num[NUM_W-2:0], ge};
    end
  end

  // clamp to max first, then min, so min wins when they cross
  assign q_hi_clamp = (num > NUM_W'(max_gain)) ? max_gain : num[GAIN_W-1:0];
  assign goal_next  = (q_hi_clamp < min_gain) ? min_gain : q_hi_clamp;

  always_ff @(posedge clk) begin
    if (cmd.clamp) begin
      goal <= goal_next;
    end
  end

  // gap times coefficient, upper bits kept
  assign rising   = (goal > cur_gain);
  assign falling  = (goal < cur_gain);
  assign gap_comb = rising ? (goal - cur_gain) : (cur_gain - goal);
  assign coef_sel = rising ? attack_coef : release_coef;
  assign prod     = (GAIN_W + COEF_W)'(gap_comb) * (GAIN_W + COEF_W)'(coef_sel);

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      gap   <= gap_comb;
      delta <= prod[GAIN_W+COEF_W-1:COEF_FRAC];
      up    <= rising;
      down  <= falling;
    end
  end

  // step toward the goal without passing it
  assign sum = {2'b00, cur_gain} + {1'b0, delta};

  always_comb begin
    cur_gain_next = cur_gain;
    priority if (up) begin
      cur_gain_next = (sum > {2'b00, goal}) ? goal : sum[GAIN_W-1:0];
    end else if (down) begin
      cur_gain_next = (delta >= {1'b0, gap}) ? goal : (cur_gain - delta[GAIN_W-1:0]);
    end else begin
      // goal equals the kept gain
      cur_gain_next = cur_gain;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_gain <= GAIN_ONE;
    end else if (cmd.commit) begin
      cur_gain <= cur_gain_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      gain      <= cur_gain_next;
      goal_gain <= goal;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/agc_gain_smoother.sv @@
// top level of the agc gain smoother
`timescale 1ns / 1ps
`default_nettype none

// Automatic gain control with attack/release smoothing. Each input beat carries
// one measured level (zero counts as one). The goal gain is target_level * 256 /
// level, unsigned Q8.8 and truncated, clamped to max_gain and then to min_gain.
// The kept gain (reset 1.0) moves toward the goal by the gap times attack_coef
// when rising or release_coef when falling (Q1.16, truncated) and never passes
// the goal. Each input beat gives exactly one output beat with the new gain and
// the goal. The block takes one item at a time and runs it through the accept,
// the restoring divider (one quotient bit per cycle over the 24-bit dividend),
// then the clamp, the 17x16 multiply and the gain update. A finished result sits
// in the output register, so a new item is accepted while it waits; the update
// of that next item holds until the output register drains. Config writes are
// always ready and take effect at once; write them only while the block is idle.

module agc_gain_smoother #(
  parameter  int LEVEL_BITS = 16,
  localparam int S_TDATA_W  = ((LEVEL_BITS + 7) / 8) * 8
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // input stream
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [S_TDATA_W-1:0]           s_tdata,   // level
  // output stream
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic [agc_pkg::M_TDATA_W-1:0]       m_tdata,   // gain, goal_gain
  // config write channel
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [agc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [agc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import agc_pkg::*;

  agc_cmd_t          cmd;
  agc_sts_t          sts;
  logic [GAIN_W-1:0] gain;
  logic [GAIN_W-1:0] goal_gain;

  // config beats never stall
  assign cfg_ready = 1'b1;

  // gain in the low half, goal above it
  assign m_tdata = {goal_gain, gain};

  agc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  agc_dp #(
    .LEVEL_BITS (LEVEL_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .level     (s_tdata[LEVEL_BITS-1:0]),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .gain      (gain),
    .goal_gain (goal_gain)
  );

endmodule

`default_nettype wire

@@ rtl/core/agc_checker.sv @@
// port-level assertions for the agc gain smoother, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

`include "agc_gain_smoother_macros.svh"

module agc_port_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          s_tvalid,
  input wire logic                          s_tready,
  input wire logic                          m_tvalid,
  input wire logic                          m_tready,
  input wire logic [agc_pkg::M_TDATA_W-1:0] m_tdata,
  input wire logic                          cfg_ready
);

  // a stalled output beat keeps its payload
  `AGC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  // one item at a time: busy right after an accept
  `AGC_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
  // a fresh result is posted only as the block goes idle again
  `AGC_ASSERT_NOW(a_result_frees_input, $rose(m_tvalid), s_tready)
  // config channel never stalls
  `AGC_ASSERT_NOW(a_cfg_ready, 1'b1, cfg_ready)

endmodule

bind agc_gain_smoother agc_port_checker u_agc_checker (
  .clk       (clk),
  .rst       (rst),
  .s_tvalid  (s_tvalid),
  .s_tready  (s_tready),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .cfg_ready (cfg_ready)
);

`default_nettype wire

@@ dv/agc_checker.sv @@
// scoreboard for the agc gain smoother: predicts each output beat and compares it
`timescale 1ns / 1ps

module agc_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  input  logic                                s_tready,
  input  logic [15:0]                         s_tdata,   // level
  input  logic                                m_tvalid,
  input  logic                                m_tready,
  input  logic [agc_pkg::M_TDATA_W-1:0]       m_tdata,   // gain, goal_gain
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [agc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [agc_pkg::CFG_DATA_W-1:0]      cfg_data,
  output int                                  errors,
  output int                                  outstanding,
  output int                                  checked,
  output int                                  rises,
  output int                                  falls,
  output int                                  holds
);
  import agc_pkg::*;

  // packed so that gain sits in the low half, as on m_tdata
  typedef struct packed {
    logic [GAIN_W-1:0] goal;
    logic [GAIN_W-1:0] gain;
  } gain_beat_t;

  logic [GAIN_W-1:0] tgt_lvl;
  logic [GAIN_W-1:0] min_g;
  logic [GAIN_W-1:0] max_g;
  logic [COEF_W-1:0] att_c;
  logic [COEF_W-1:0] rel_c;
  logic [GAIN_W-1:0] gain_now;
  gain_beat_t        gain_q[$];

  // goal from level, then one attack or release step toward it
  function automatic gain_beat_t next_gain(input logic [15:0] lvl, input logic [GAIN_W-1:0] cur);
    logic [63:0] q;
    logic [63:0] gap;
    logic [63:0] delta;
    gain_beat_t  r;
    q = {40'd0, tgt_lvl, 8'd0} / ((lvl == 16'd0) ? 64'd1 : {48'd0, lvl});
    if (q > 64'(max_g)) q = 64'(max_g);
    if (q < 64'(min_g)) q = 64'(min_g);
    r.goal = q[GAIN_W-1:0];
    r.gain = cur;
    if (q > 64'(cur)) begin
      gap = q - 64'(cur);
      delta = (gap * 64'(att_c)) >> COEF_FRAC;
      if (64'(cur) + delta > q) r.gain = r.goal;
      else r.gain = cur + delta[GAIN_W-1:0];
    end else if (q < 64'(cur)) begin
      gap = 64'(cur) - q;
      delta = (gap * 64'(rel_c)) >> COEF_FRAC;
      if (delta >= gap) r.gain = r.goal;
      else r.gain = cur - delta[GAIN_W-1:0];
    end
    return r;
  endfunction

  always @(posedge clk) begin
    gain_beat_t want;
    gain_beat_t got;
    if (rst) begin
      tgt_lvl = TARGET_LEVEL_RST;
      min_g = MIN_GAIN_RST;
      max_g = MAX_GAIN_RST;
      att_c = ATTACK_COEF_RST;
      rel_c = RELEASE_COEF_RST;
      gain_now = GAIN_ONE;
      gain_q.delete();
      errors = 0;
      checked = 0;
      rises = 0;
      falls = 0;
      holds = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TARGET_LEVEL: tgt_lvl = cfg_data[GAIN_W-1:0];
          REG_MIN_GAIN:     min_g = cfg_data[GAIN_W-1:0];
          REG_MAX_GAIN:     max_g = cfg_data[GAIN_W-1:0];
          REG_ATTACK_COEF:  att_c = cfg_data[COEF_W-1:0];
          REG_RELEASE_COEF: rel_c = cfg_data[COEF_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        want = next_gain(s_tdata, gain_now);
        if (want.gain > gain_now) rises++;
        else if (want.gain < gain_now) falls++;
        else holds++;
        gain_now = want.gain;
        gain_q.push_back(want);
      end
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (gain_q.size() == 0) begin
          $display("%0t: unexpected output beat, expected none, got gain %0d goal %0d",
                   $time, got.gain, got.goal);
          errors++;
        end else begin
          want = gain_q.pop_front();
          checked++;
          if (got.gain !== want.gain) begin
            $display("%0t: gain mismatch, expected %0d, got %0d", $time, want.gain, got.gain);
            errors++;
          end
          if (got.goal !== want.goal) begin
            $display("%0t: goal_gain mismatch, expected %0d, got %0d",
                     $time, want.goal, got.goal);
            errors++;
          end
        end
      end
    end
    outstanding = gain_q.size();
  end

endmodule

@@ dv/tb_top.sv @@
// testbench top of the agc gain smoother: stimulus, stalls and verdict
`timescale 1ns / 1ps

module tb_top;
  import agc_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_CYCLES = 400;     // long receiver hold-off, fills the block
  localparam int RAND_PHASES = 8;
  localparam int PHASE_ITEMS = 210;
  localparam int TAIL_CYCLES = 40;      // longer than one item's pass through the block
  localparam logic [CFG_IDX_W-1:0] REG_IDX_TOP = '1;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  // block ports, inputs driven to known values from time zero
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [15:0]            s_tdata = '0;      // level
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [M_TDATA_W-1:0]   m_tdata;           // gain, goal_gain
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // results from the checker
  int errors;
  int outstanding;
  int checked;
  int rises;
  int falls;
  int holds;

  // knobs shared between the stimulus and the receiver process
  int   src_pct = 0;        // chance in percent of a gap before a level beat
  int   stall_pct = 0;      // chance in percent per cycle of a receiver stall
  logic hold_req = 1'b0;    // asks the receiver for the one long hold-off
  logic hold_done = 1'b0;
  int   hold_left = 0;
  int   stall_left = 0;
  int   cycles = 0;

  // stimulus bookkeeping for the summary
  int          levels_sent = 0;
  int          settings_used = 0;
  int          reg_writes = 0;
  logic [15:0] tgt_now = TARGET_LEVEL_RST;

  agc_gain_smoother u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  agc_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .errors      (errors),
    .outstanding (outstanding),
    .checked     (checked),
    .rises       (rises),
    .falls       (falls),
    .holds       (holds)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // watchdog: a hung handshake ends the run as a failure
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still expected", cycles, outstanding);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver: random stall bursts, plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      m_tready <= 1'b0;
      hold_left <= HOLD_CYCLES - 1;
      hold_done <= 1'b1;
    end else if (stall_left != 0) begin
      m_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      m_tready <= 1'b0;
      stall_left <= $urandom_range(0, 13);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // one level beat; may open with a sender gap, leaves tvalid high on return
  task automatic send_level(input logic [15:0] lvl);
    int gap;
    if (src_pct != 0 && $urandom_range(0, 99) < src_pct) begin
      gap = $urandom_range(1, 14);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= lvl;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    levels_sent++;
  endtask

  // one register write; cfg_valid stays high until end_writes
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    reg_writes++;
    if (idx == REG_TARGET_LEVEL) tgt_now = val[15:0];
  endtask

  task automatic end_writes();
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // stop sending and wait until every predicted beat has come out
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // levels: full range, small, near the target, the rails and single bits
  function automatic logic [15:0] pick_level(input logic [15:0] tgt);
    logic [15:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = 16'($urandom_range(0, 16'hFFFF));
      4, 5:       v = 16'($urandom_range(0, 255));
      6, 7:       v = tgt + 16'($urandom_range(0, 64)) - 16'd32;
      8:          v = $urandom_range(0, 1) ? 16'h0000 : 16'hFFFF;
      default:    v = 16'h0001 << $urandom_range(0, 15);
    endcase
    return v;
  endfunction

  // coefficients: zero, exactly one, above one (overshoot) or a plain fraction
  function automatic logic [CFG_DATA_W-1:0] pick_coef();
    logic [CFG_DATA_W-1:0] c;
    case ($urandom_range(0, 7))
      0:       c = '0;
      1:       c = 17'h10000;
      2:       c = CFG_DATA_W'($urandom_range(17'h10001, 17'h1FFFF));
      3:       c = CFG_DATA_W'($urandom_range(1, 64));
      default: c = CFG_DATA_W'($urandom_range(1, 17'hFFFF));
    endcase
    return c;
  endfunction

  // a fresh random setting of all five registers, sometimes with stray writes
  task automatic random_settings();
    logic [CFG_DATA_W-1:0] t;
    logic [CFG_DATA_W-1:0] lo;
    logic [CFG_DATA_W-1:0] hi;
    t  = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'(TARGET_LEVEL_RST)
                                     : CFG_DATA_W'($urandom_range(0, 17'h1FFFF));
    lo = ($urandom_range(0, 4) == 0) ? CFG_DATA_W'($urandom_range(0, 17'h1FFFF))
                                     : CFG_DATA_W'($urandom_range(0, 1024));
    hi = ($urandom_range(0, 4) == 0) ? CFG_DATA_W'($urandom_range(0, 17'h1FFFF))
                                     : CFG_DATA_W'($urandom_range(1024, 17'h1FFFF));
    write_reg(REG_TARGET_LEVEL, t);
    write_reg(REG_MIN_GAIN, lo);
    write_reg(REG_MAX_GAIN, hi);
    write_reg(REG_ATTACK_COEF, pick_coef());
    write_reg(REG_RELEASE_COEF, pick_coef());
    // unmapped indexes must leave every register alone
    if ($urandom_range(0, 1) == 0)
      write_reg(CFG_IDX_W'($urandom_range(REG_RELEASE_COEF + 1, REG_IDX_TOP)),
                CFG_DATA_W'($urandom_range(0, 17'h1FFFF)));
    end_writes();
  endtask

  initial begin : stimulus
    int p;
    int sent;
    int run_len;
    int k;
    logic [15:0] lvl;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset settings, goal equal to the 1.0 gain, zero level, the rails
    send_level(16'd16384);
    send_level(16'h0000);
    send_level(16'h0001);
    send_level(16'hFFFF);
    send_level(16'h8000);
    send_level(16'h5555);
    send_level(16'hAAAA);
    drain();

    // min above max so min wins; coefficients above one overshoot onto the goal;
    // bit 16 on a 16-bit register is dropped; an unmapped index is ignored
    write_reg(REG_TARGET_LEVEL, 17'h0FFFF);
    write_reg(REG_MIN_GAIN, 17'h12328);
    write_reg(REG_MAX_GAIN, 17'd100);
    write_reg(REG_ATTACK_COEF, 17'h1FFFF);
    write_reg(REG_RELEASE_COEF, 17'h1FFFF);
    write_reg(REG_IDX_TOP, 17'h1FFFF);
    end_writes();
    send_level(16'h0001);
    send_level(16'hFFFF);
    drain();

    // zero target: goal of zero, release overshoot lands on it
    write_reg(REG_MIN_GAIN, 17'd0);
    write_reg(REG_MAX_GAIN, 17'h1FFFF);
    write_reg(REG_TARGET_LEVEL, 17'd0);
    end_writes();
    send_level(16'h0000);
    send_level(16'h7FFF);
    drain();

    // full target against a level of one: goal at the top of the range
    write_reg(REG_TARGET_LEVEL, 17'h0FFFF);
    end_writes();
    send_level(16'h0001);
    drain();

    // tiny coefficients: the truncated step is zero and the gain sits still
    write_reg(REG_ATTACK_COEF, 17'd1);
    write_reg(REG_RELEASE_COEF, 17'd1);
    end_writes();
    send_level(16'h8000);
    send_level(16'h00FF);
    drain();

    // coefficients of exactly one close the whole gap in one step
    write_reg(REG_TARGET_LEVEL, 17'd16384);
    write_reg(REG_MIN_GAIN, 17'd64);
    write_reg(REG_MAX_GAIN, 17'd8192);
    write_reg(REG_ATTACK_COEF, 17'h10000);
    write_reg(REG_RELEASE_COEF, 17'h10000);
    end_writes();
    send_level(16'h0100);
    send_level(16'h1234);
    send_level(16'h4321);
    drain();

    // random phases: steady runs let the gain settle, single beats jerk it around
    for (p = 0; p < RAND_PHASES; p++) begin
      random_settings();
      if (p == RAND_PHASES - 1) begin
        // last phase runs flat out on both sides
        src_pct = 0;
        stall_pct = 0;
      end else begin
        src_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
        stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 20);
      end
      // second phase: receiver holds off long while levels keep coming
      if (p == 1) hold_req <= 1'b1;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        run_len = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 30) : 1;
        lvl = pick_level(tgt_now);
        for (k = 0; k < run_len && sent < PHASE_ITEMS; k++) begin
          send_level(lvl);
          sent++;
        end
      end
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);

    $display("run covered %0d level beats under %0d register settings (%0d writes)",
             levels_sent, settings_used, reg_writes);
    $display("checked %0d result beats: gain rose %0d, fell %0d, held %0d times",
             checked, rises, falls, holds);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
